// ----- sv/bsia_pkg.sv -----
// Package for the bitmap slot ID allocator: sizes, operation and status codes,
// and the control state type. No dependencies.
package bsia_pkg;

    localparam int NUM_UNITS      = 256;
    localparam int SLOTS_PER_UNIT = 64;
    localparam int VALUE_WIDTH    = 64;

    localparam int UNIT_W  = $clog2(NUM_UNITS);
    localparam int HEAD_W  = UNIT_W + 1;
    localparam int SLOT_W  = $clog2(SLOTS_PER_UNIT);
    localparam int ID_W    = 14;
    localparam int CNT_W   = 15;
    localparam int TOTAL_SLOTS = NUM_UNITS * SLOTS_PER_UNIT;
    localparam int SADDR_W = UNIT_W + SLOT_W;

    localparam logic [HEAD_W-1:0] HEAD_EMPTY = HEAD_W'(NUM_UNITS);
    localparam logic [ID_W-1:0]   KEY_LIMIT_RESET = '1;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_UNSET = 2'd1,
        ACT_RESET = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic {
        FSM_IDLE,
        FSM_EXEC
    } fsm_t;

endpackage

// ----- sv/bitmap_slot_id_allocator_unit.sv -----
// Bitmap slot ID allocator: unit bitmaps, free-unit links and slot values in
// synchronous memories, read at accept and written back in the EXEC state.
// Depends on bsia_pkg.
//
//   channel  | dir | handshake            | payload
//   ---------+-----+----------------------+----------------------------------
//   s_       | in  | s_tvalid / s_tready  | s_tuser action, s_tdata id+value
//   m_       | out | m_tvalid / m_tready  | m_tuser status, m_tdata id+counts
//   cfg_     | in  | cfg_wr_en            | cfg_wr_data key_limit
//
// Per item, the accept edge in IDLE reads the bitmap and link memories, and
// in EXEC the block computes, writes back and loads the output register.
// The write-back lands before the next accept, so the same unit is never
// read stale. A result waiting in the output register stalls only the
// write-back cycle of the following item. After reset the block is ready at
// once; memory contents are undefined until written.
module bitmap_slot_id_allocator_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // [1:0] action
    input  logic [79:0] s_tdata,   // [13:0] key_id, [77:14] key_value, [79:78] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic [47:0] m_tdata,   // [13:0] assigned_id, [28:14] key_count,
                                   // [43:29] highest_id, [47:44] zero
    input  logic        cfg_wr_en,
    input  logic [13:0] cfg_wr_data
);
    import bsia_pkg::*;

    // memories
    logic [SLOTS_PER_UNIT-1:0] bitmap_mem [NUM_UNITS];
    logic [HEAD_W-1:0]         link_mem   [NUM_UNITS];
    logic [VALUE_WIDTH-1:0]    value_mem  [TOTAL_SLOTS];

    fsm_t state_reg, state_next;

    logic [ID_W-1:0]           key_limit_reg;
    logic [HEAD_W-1:0]         free_head_reg, free_head_next;
    logic [CNT_W-1:0]          fresh_id_reg, fresh_id_next;
    logic [CNT_W-1:0]          live_count_reg, live_count_next;

    action_t                   act_reg;
    logic [ID_W-1:0]           id_reg;
    logic [VALUE_WIDTH-1:0]    value_reg;
    logic [SLOTS_PER_UNIT-1:0] bm_rd_reg;
    logic [HEAD_W-1:0]         lk_rd_reg;

    logic                      m_valid_reg, m_valid_next;
    status_t                   m_status_reg, m_status_next;
    logic [ID_W-1:0]           m_id_reg, m_id_next;
    logic [CNT_W-1:0]          m_count_reg, m_count_next;
    logic [CNT_W-1:0]          m_high_reg, m_high_next;

    logic                      accept;
    logic                      exec_go;
    logic [UNIT_W-1:0]         rd_addr;

    logic                      bm_we, lk_we, val_we;
    logic [UNIT_W-1:0]         wr_unit;
    logic [SLOTS_PER_UNIT-1:0] bm_wdata;
    logic [HEAD_W-1:0]         lk_wdata;
    logic [SADDR_W-1:0]        val_addr;

    logic [SLOTS_PER_UNIT-1:0] zero_bits, zero_onehot, new_bits, id_onehot;
    logic [SLOT_W-1:0]         low_zero;
    logic [ID_W-1:0]           head_id;
    logic [CNT_W-1:0]          id_plus1;
    logic [ID_W-1:0]           add_id;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE: if (s_tvalid) state_next = FSM_EXEC;
            FSM_EXEC: if (!m_valid_reg || m_tready) state_next = FSM_IDLE;
            default:  state_next = FSM_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready = 1'b0;
        exec_go  = 1'b0;
        unique case (state_reg)
            FSM_IDLE: s_tready = 1'b1;
            FSM_EXEC: exec_go  = !m_valid_reg || m_tready;
            default:  s_tready = 1'b0;
        endcase
    end

    assign accept  = s_tvalid && s_tready;
    assign rd_addr = (action_t'(s_tuser) == ACT_ADD) ? free_head_reg[UNIT_W-1:0]
                                                     : s_tdata[ID_W-1:SLOT_W];

    // lowest clear bit of the head unit
    assign zero_bits   = ~bm_rd_reg;
    assign zero_onehot = zero_bits & (~zero_bits + SLOTS_PER_UNIT'(1));
    always_comb begin
        low_zero = '0;
        for (int i = 0; i < SLOTS_PER_UNIT; i++) begin
            if (zero_onehot[i]) low_zero = low_zero | SLOT_W'(i);
        end
    end
    assign head_id   = {free_head_reg[UNIT_W-1:0], low_zero};
    assign id_onehot = SLOTS_PER_UNIT'(1) << id_reg[SLOT_W-1:0];

    // compute and write back
    always_comb begin
        free_head_next  = free_head_reg;
        fresh_id_next   = fresh_id_reg;
        live_count_next = live_count_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_id_next       = m_id_reg;
        m_count_next    = m_count_reg;
        m_high_next     = m_high_reg;
        bm_we    = 1'b0;
        lk_we    = 1'b0;
        val_we   = 1'b0;
        wr_unit  = id_reg[ID_W-1:SLOT_W];
        bm_wdata = bm_rd_reg;
        lk_wdata = HEAD_EMPTY;
        val_addr = SADDR_W'(id_reg);
        new_bits = bm_rd_reg | zero_onehot;
        add_id   = head_id;
        id_plus1 = CNT_W'(head_id) + CNT_W'(1);

        if (m_valid_reg && m_tready) m_valid_next = 1'b0;

        if (exec_go) begin
            m_status_next = ST_NOT_FOUND;
            m_id_next     = '0;
            unique case (act_reg)
                ACT_ADD: begin
                    if (free_head_reg[HEAD_W-1]) begin
                        // open a fresh unit after the highest issued ID
                        add_id   = fresh_id_reg[ID_W-1:0];
                        id_plus1 = fresh_id_reg + CNT_W'(1);
                        if (fresh_id_reg[CNT_W-1] ||
                            fresh_id_reg[ID_W-1:0] > key_limit_reg) begin
                            m_status_next = ST_FULL;
                        end else begin
                            m_status_next  = ST_OK;
                            wr_unit        = fresh_id_reg[ID_W-1:SLOT_W];
                            bm_we          = 1'b1;
                            bm_wdata       = SLOTS_PER_UNIT'(1) << fresh_id_reg[SLOT_W-1:0];
                            lk_we          = 1'b1;
                            lk_wdata       = HEAD_EMPTY;
                            free_head_next = {1'b0, fresh_id_reg[ID_W-1:SLOT_W]};
                        end
                    end else if (&bm_rd_reg || head_id > key_limit_reg) begin
                        m_status_next = ST_FULL;
                    end else begin
                        m_status_next = ST_OK;
                        wr_unit       = free_head_reg[UNIT_W-1:0];
                        bm_we         = 1'b1;
                        bm_wdata      = new_bits;
                        // unit now full: drop it from the list
                        if (&new_bits) free_head_next = lk_rd_reg;
                    end
                    if (m_status_next == ST_OK) begin
                        m_id_next       = add_id;
                        val_we          = 1'b1;
                        val_addr        = SADDR_W'(add_id);
                        live_count_next = live_count_reg + CNT_W'(1);
                        if (id_plus1 > fresh_id_reg) fresh_id_next = id_plus1;
                    end
                end
                ACT_UNSET: begin
                    if ({1'b0, id_reg} < fresh_id_reg && |(bm_rd_reg & id_onehot)) begin
                        m_status_next = ST_OK;
                        if (&bm_rd_reg) begin
                            // unit was full: push it onto the list
                            lk_we          = 1'b1;
                            lk_wdata       = free_head_reg;
                            free_head_next = {1'b0, id_reg[ID_W-1:SLOT_W]};
                        end
                        bm_we           = 1'b1;
                        bm_wdata        = bm_rd_reg & ~id_onehot;
                        live_count_next = live_count_reg - CNT_W'(1);
                    end
                end
                ACT_RESET: begin
                    if ({1'b0, id_reg} < fresh_id_reg && |(bm_rd_reg & id_onehot)) begin
                        m_status_next = ST_OK;
                        val_we        = 1'b1;
                    end
                end
                ACT_NONE: m_status_next = ST_NOT_FOUND;
                default:  m_status_next = ST_NOT_FOUND;
            endcase
            m_valid_next = 1'b1;
            m_count_next = live_count_next;
            m_high_next  = fresh_id_next - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= FSM_IDLE;
            key_limit_reg  <= KEY_LIMIT_RESET;
            free_head_reg  <= HEAD_EMPTY;
            fresh_id_reg   <= '0;
            live_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            free_head_reg  <= free_head_next;
            fresh_id_reg   <= fresh_id_next;
            live_count_reg <= live_count_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en) key_limit_reg <= cfg_wr_data;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg   <= action_t'(s_tuser);
            id_reg    <= s_tdata[ID_W-1:0];
            value_reg <= s_tdata[ID_W +: VALUE_WIDTH];
        end
        m_status_reg <= m_status_next;
        m_id_reg     <= m_id_next;
        m_count_reg  <= m_count_next;
        m_high_reg   <= m_high_next;
    end

    // memory ports
    always_ff @(posedge aclk) begin
        if (accept) begin
            bm_rd_reg <= bitmap_mem[rd_addr];
            lk_rd_reg <= link_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (bm_we) bitmap_mem[wr_unit] <= bm_wdata;
    end

    always_ff @(posedge aclk) begin
        if (lk_we) link_mem[wr_unit] <= lk_wdata;
    end

    always_ff @(posedge aclk) begin
        if (val_we) value_mem[val_addr] <= value_reg;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {4'b0, m_high_reg, m_count_reg, m_id_reg};

endmodule
